// File: src/central_gravity_body_step_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the central gravity body step core
// Concurrent checks clocked on clk_i and held off during reset.
// ----------------------------------------------------------------------------
`ifndef CENTRAL_GRAVITY_BODY_STEP_CORE_MACROS_SVH
`define CENTRAL_GRAVITY_BODY_STEP_CORE_MACROS_SVH

// Property must hold at every edge outside reset.
`define CGBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent must follow the antecedent by non-overlapping implication.
`define CGBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/cgbs_pkg.sv
// ----------------------------------------------------------------------------
// cgbs_pkg
// Types, widths, register codes and saturation helpers of the body step core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cgbs_pkg;

  localparam int unsigned POS_W  = 24;
  localparam int unsigned VEL_W  = 20;
  localparam int unsigned RAD_W  = 16;
  localparam int unsigned MASS_W = 24;
  localparam int unsigned SRAD_W = 12;
  localparam int unsigned DIF_W  = 25;  // magnitude of a center difference
  localparam int unsigned D2_W   = 50;  // squared distance
  localparam int unsigned ROOT_W = 25;  // floor of the distance
  localparam int unsigned MAG_QW = 42;  // quotient bits kept of the magnitude
  localparam int unsigned UNIT_W = 17;  // unit vector component, Q16
  localparam int unsigned ACC_W  = 21;  // clamped acceleration magnitude
  localparam int unsigned IDX_W  = 2;

  typedef enum logic [IDX_W-1:0] {
    REG_STAR_MASS   = 2'd0,
    REG_STAR_CX     = 2'd1,
    REG_STAR_CY     = 2'd2,
    REG_STAR_RADIUS = 2'd3
  } cfg_reg_e;

  localparam logic [MASS_W-1:0]        RST_STAR_MASS   = 24'd100000;
  localparam logic signed [POS_W-1:0]  RST_STAR_CX     = 24'sd163840;
  localparam logic signed [POS_W-1:0]  RST_STAR_CY     = 24'sd131072;
  localparam logic [SRAD_W-1:0]        RST_STAR_RADIUS = 12'd80;

  typedef struct packed {
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
    logic [RAD_W-1:0]        br;
    logic                    act;
  } body_t;

  // Item data that rides alongside the arithmetic lanes.
  typedef struct packed {
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
    logic                    hit;
    logic                    move;
    logic                    zero;
  } side_t;

  function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [VEL_W+2:0] v);
    logic signed [VEL_W+2:0] hi;
    logic signed [VEL_W+2:0] lo;
    hi = (VEL_W+3)'(2**(VEL_W-1) - 1);
    lo = -hi - (VEL_W+3)'(1);
    if (v > hi)      sat_vel = hi[VEL_W-1:0];
    else if (v < lo) sat_vel = lo[VEL_W-1:0];
    else             sat_vel = v[VEL_W-1:0];
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W:0] v);
    if (v[POS_W] != v[POS_W-1]) begin
      sat_pos = v[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      sat_pos = v[POS_W-1:0];
    end
  endfunction

endpackage

// File: src/cgbs_div.sv
// ----------------------------------------------------------------------------
// cgbs_div
// Pipelined restoring divider, one quotient bit per stage, saturating.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cgbs_div #(
  parameter int unsigned NW = 52,
  parameter int unsigned DW = 50,
  parameter int unsigned QW = 42,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] sb_i,
  output logic          vld_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] sb_o
);

  logic          vld_q [QW];
  logic [DW-1:0] rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] num_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic          ovf_q [QW];
  logic [SW-1:0] sb_q  [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic          vld_p;
    logic [DW-1:0] rem_p;
    logic [DW-1:0] den_p;
    logic [QW-1:0] num_p;
    logic [QW-1:0] quo_p;
    logic          ovf_p;
    logic [SW-1:0] sb_p;
    logic [DW:0]   trial;
    logic          ge;
    logic [DW-1:0] rem_d;
    logic [QW-1:0] quo_d;

    if (s == 0) begin : g_entry
      // Upper numerator bits start the remainder; they must stay below the divisor.
      assign rem_p = {{(DW-(NW-QW)){1'b0}}, num_i[NW-1:QW]};
      assign ovf_p = (rem_p >= den_i);
      assign vld_p = vld_i;
      assign den_p = den_i;
      assign num_p = num_i[QW-1:0];
      assign quo_p = '0;
      assign sb_p  = sb_i;
    end else begin : g_mid
      assign rem_p = rem_q[s-1];
      assign ovf_p = ovf_q[s-1];
      assign vld_p = vld_q[s-1];
      assign den_p = den_q[s-1];
      assign num_p = num_q[s-1];
      assign quo_p = quo_q[s-1];
      assign sb_p  = sb_q[s-1];
    end

    always_comb begin
      trial = {rem_p, num_p[QW-1-s]};
      ge    = (trial >= {1'b0, den_p});
      rem_d = ge ? DW'(trial - {1'b0, den_p}) : trial[DW-1:0];
      quo_d = quo_p;
      quo_d[QW-1-s] = ge;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d;
        den_q[s] <= den_p;
        num_q[s] <= num_p;
        quo_q[s] <= quo_d;
        ovf_q[s] <= ovf_p;
        sb_q[s]  <= sb_p;
      end
    end
  end

  assign vld_o = vld_q[QW-1];
  assign quo_o = ovf_q[QW-1] ? {QW{1'b1}} : quo_q[QW-1];
  assign sb_o  = sb_q[QW-1];

endmodule

// File: src/cgbs_sqrt.sv
// ----------------------------------------------------------------------------
// cgbs_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cgbs_sqrt #(
  parameter int unsigned RW = 25,
  parameter int unsigned SW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  logic [2*RW-1:0] x_i,
  input  logic [SW-1:0]   sb_i,
  output logic            vld_o,
  output logic [RW-1:0]   root_o,
  output logic [SW-1:0]   sb_o
);

  logic            vld_q  [RW];
  logic [RW+1:0]   rem_q  [RW];
  logic [RW-1:0]   root_q [RW];
  logic [2*RW-1:0] x_q    [RW];
  logic [SW-1:0]   sb_q   [RW];

  for (genvar s = 0; s < RW; s++) begin : g_stage
    localparam int unsigned K = RW - 1 - s;
    logic            vld_p;
    logic [RW+1:0]   rem_p;
    logic [RW-1:0]   root_p;
    logic [2*RW-1:0] x_p;
    logic [SW-1:0]   sb_p;
    logic [RW+3:0]   trial;
    logic [RW+3:0]   sub;
    logic            ge;
    logic [RW+1:0]   rem_d;
    logic [RW-1:0]   root_d;

    if (s == 0) begin : g_entry
      assign vld_p  = vld_i;
      assign rem_p  = '0;
      assign root_p = '0;
      assign x_p    = x_i;
      assign sb_p   = sb_i;
    end else begin : g_mid
      assign vld_p  = vld_q[s-1];
      assign rem_p  = rem_q[s-1];
      assign root_p = root_q[s-1];
      assign x_p    = x_q[s-1];
      assign sb_p   = sb_q[s-1];
    end

    always_comb begin
      trial  = {rem_p, x_p[2*K+1 -: 2]};
      sub    = {2'b00, root_p, 2'b01};
      ge     = (trial >= sub);
      rem_d  = ge ? (RW+2)'(trial - sub) : trial[RW+1:0];
      root_d = {root_p[RW-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d;
        root_q[s] <= root_d;
        x_q[s]    <= x_p;
        sb_q[s]   <= sb_p;
      end
    end
  end

  assign vld_o  = vld_q[RW-1];
  assign root_o = root_q[RW-1];
  assign sb_o   = sb_q[RW-1];

endmodule

// File: src/central_gravity_body_step_core.sv
// ----------------------------------------------------------------------------
// central_gravity_body_step_core
// One tick of semi-implicit Euler motion of a body around a fixed star.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  s_axis   | in        | tdata: pos_x, pos_y, vel_x, vel_y, body_radius; tuser: active
//  m_axis   | out       | tdata: new_pos_x, new_pos_y, new_vel_x, new_vel_y; tuser: removed
//  cfg      | in        | index + data write of the four star registers, always ready
//
//  One item enters per cycle unless a held result on m_axis stalls the pipeline; the path has
//  49 register stages, the first one loaded at the accepting edge.
//  The depth is set by the 42-stage divide lane (25 root stages feeding a 17-stage
//  unit-vector divide, run beside a 42-bit magnitude divide) plus seven plain stages.
//  Reset clears every valid bit and loads the star registers with their defaults.
//  A held result on m_axis freezes the whole pipeline; nothing is dropped or repeated.
`timescale 1ns / 1ps
`include "central_gravity_body_step_core_macros.svh"

module central_gravity_body_step_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // [23:0] pos_x, [47:24] pos_y, [67:48] vel_x, [87:68] vel_y, [103:88] body_radius
  input  logic [103:0]               s_axis_tdata,
  // [0] active
  input  logic                       s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // [23:0] new_pos_x, [47:24] new_pos_y, [67:48] new_vel_x, [87:68] new_vel_y
  output logic [87:0]                m_axis_tdata,
  // [0] removed
  output logic                       m_axis_tuser,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [cgbs_pkg::IDX_W-1:0] cfg_index_i,
  input  logic [23:0]                cfg_data_i
);
  import cgbs_pkg::*;

  // ---------------------------------------------------------------- registers
  logic [MASS_W-1:0]       star_mass_q;
  logic signed [POS_W-1:0] star_cx_q;
  logic signed [POS_W-1:0] star_cy_q;
  logic [SRAD_W-1:0]       star_rad_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      star_mass_q <= RST_STAR_MASS;
      star_cx_q   <= RST_STAR_CX;
      star_cy_q   <= RST_STAR_CY;
      star_rad_q  <= RST_STAR_RADIUS;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_STAR_MASS:   star_mass_q <= cfg_data_i[MASS_W-1:0];
        REG_STAR_CX:     star_cx_q   <= cfg_data_i[POS_W-1:0];
        REG_STAR_CY:     star_cy_q   <= cfg_data_i[POS_W-1:0];
        REG_STAR_RADIUS: star_rad_q  <= cfg_data_i[SRAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Whole pipeline advances together whenever the output slot is free or draining.
  logic pipe_en;
  logic out_vld_q;
  assign pipe_en       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = pipe_en;

  // ---------------------------------------------------------------- stage 1: capture
  logic  s1_vld_q;
  body_t s1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_vld_q <= 1'b0;
    else if (pipe_en) s1_vld_q <= s_axis_tvalid;
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s1_q.px  <= s_axis_tdata[23:0];
      s1_q.py  <= s_axis_tdata[47:24];
      s1_q.vx  <= s_axis_tdata[67:48];
      s1_q.vy  <= s_axis_tdata[87:68];
      s1_q.br  <= s_axis_tdata[103:88];
      s1_q.act <= s_axis_tuser;
    end
  end

  // ---------------------------------------------------------------- stage 2: box test, deltas
  logic signed [DIF_W-1:0] dx, dy;
  logic signed [26:0]      sr_ext, br_ext;
  logic signed [26:0]      bxl, bxr, sxl, sxr, byl, byr, syl, syr;
  logic                    hit_x, hit_y;

  always_comb begin
    sr_ext = 27'($signed({1'b0, star_rad_q, 8'h00}));
    br_ext = 27'($signed({1'b0, s1_q.br}));
    bxl = 27'(s1_q.px) - br_ext;
    bxr = 27'(s1_q.px) + br_ext;
    sxl = 27'(star_cx_q) - sr_ext;
    sxr = 27'(star_cx_q) + sr_ext;
    byl = 27'(s1_q.py) - br_ext;
    byr = 27'(s1_q.py) + br_ext;
    syl = 27'(star_cy_q) - sr_ext;
    syr = 27'(star_cy_q) + sr_ext;
    // max(lefts) < min(rights) splits into four strict compares per axis
    hit_x = (bxl < bxr) && (bxl < sxr) && (sxl < bxr) && (sxl < sxr);
    hit_y = (byl < byr) && (byl < syr) && (syl < byr) && (syl < syr);
    dx = DIF_W'(star_cx_q) - DIF_W'(s1_q.px);
    dy = DIF_W'(star_cy_q) - DIF_W'(s1_q.py);
  end

  logic             s2_vld_q;
  side_t            s2_side_q;
  logic [DIF_W-1:0] s2_adx_q, s2_ady_q;
  logic             s2_sdx_q, s2_sdy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_vld_q <= 1'b0;
    else if (pipe_en) s2_vld_q <= s1_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s2_side_q.px   <= s1_q.px;
      s2_side_q.py   <= s1_q.py;
      s2_side_q.vx   <= s1_q.vx;
      s2_side_q.vy   <= s1_q.vy;
      s2_side_q.hit  <= hit_x && hit_y;
      s2_side_q.move <= !(hit_x && hit_y) && s1_q.act;
      s2_side_q.zero <= 1'b0;
      s2_adx_q       <= dx[DIF_W-1] ? DIF_W'(-dx) : DIF_W'(dx);
      s2_ady_q       <= dy[DIF_W-1] ? DIF_W'(-dy) : DIF_W'(dy);
      s2_sdx_q       <= dx[DIF_W-1];
      s2_sdy_q       <= dy[DIF_W-1];
    end
  end

  // ---------------------------------------------------------------- stage 3: squares
  logic             s3_vld_q;
  side_t            s3_side_q;
  logic [D2_W-1:0]  s3_sqx_q, s3_sqy_q;
  logic [DIF_W-1:0] s3_adx_q, s3_ady_q;
  logic             s3_sdx_q, s3_sdy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_vld_q <= 1'b0;
    else if (pipe_en) s3_vld_q <= s2_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s3_side_q <= s2_side_q;
      s3_sqx_q  <= D2_W'(s2_adx_q) * D2_W'(s2_adx_q);
      s3_sqy_q  <= D2_W'(s2_ady_q) * D2_W'(s2_ady_q);
      s3_adx_q  <= s2_adx_q;
      s3_ady_q  <= s2_ady_q;
      s3_sdx_q  <= s2_sdx_q;
      s3_sdy_q  <= s2_sdy_q;
    end
  end

  // ---------------------------------------------------------------- stage 4: squared distance
  logic             s4_vld_q;
  side_t            s4_side_q;
  side_t            s4_side_d;
  logic [D2_W-1:0]  s4_d2_q;
  logic [DIF_W-1:0] s4_adx_q, s4_ady_q;
  logic             s4_sdx_q, s4_sdy_q;
  logic [D2_W-1:0]  d2_sum;

  assign d2_sum = s3_sqx_q + s3_sqy_q;

  always_comb begin
    s4_side_d      = s3_side_q;
    s4_side_d.zero = (d2_sum == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_vld_q <= 1'b0;
    else if (pipe_en) s4_vld_q <= s3_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s4_side_q      <= s4_side_d;
      s4_d2_q        <= d2_sum;
      s4_adx_q       <= s3_adx_q;
      s4_ady_q       <= s3_ady_q;
      s4_sdx_q       <= s3_sdx_q;
      s4_sdy_q       <= s3_sdy_q;
    end
  end

  // ---------------------------------------------------------------- divide lanes
  // Magnitude lane: mass * 2^28 / dist2, saturated at 42 bits.
  logic              mag_vld;
  logic [MAG_QW-1:0] mag;
  side_t             mag_side;

  cgbs_div #(
    .NW (MASS_W + 28),
    .DW (D2_W),
    .QW (MAG_QW),
    .SW ($bits(side_t))
  ) u_mag_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .vld_i  (s4_vld_q),
    .num_i  ({star_mass_q, 28'd0}),
    .den_i  (s4_d2_q),
    .sb_i   (s4_side_q),
    .vld_o  (mag_vld),
    .quo_o  (mag),
    .sb_o   (mag_side)
  );

  // Distance lane: root first, then |d| * 2^16 / dist on each axis.
  logic                   rt_vld;
  logic [ROOT_W-1:0]      root_len;
  logic [2*DIF_W+1:0]     rt_sb;

  cgbs_sqrt #(
    .RW (ROOT_W),
    .SW (2*DIF_W + 2)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .vld_i  (s4_vld_q),
    .x_i    (s4_d2_q),
    .sb_i   ({s4_sdx_q, s4_adx_q, s4_sdy_q, s4_ady_q}),
    .vld_o  (rt_vld),
    .root_o (root_len),
    .sb_o   (rt_sb)
  );

  logic              ux_vld, uy_vld;
  logic [UNIT_W-1:0] ux, uy;
  logic              ux_sgn, uy_sgn;

  cgbs_div #(
    .NW (DIF_W + 16),
    .DW (ROOT_W),
    .QW (UNIT_W),
    .SW (1)
  ) u_ux_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .vld_i  (rt_vld),
    .num_i  ({rt_sb[2*DIF_W:DIF_W+1], 16'd0}),
    .den_i  (root_len),
    .sb_i   (rt_sb[2*DIF_W+1]),
    .vld_o  (ux_vld),
    .quo_o  (ux),
    .sb_o   (ux_sgn)
  );

  cgbs_div #(
    .NW (DIF_W + 16),
    .DW (ROOT_W),
    .QW (UNIT_W),
    .SW (1)
  ) u_uy_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .vld_i  (rt_vld),
    .num_i  ({rt_sb[DIF_W-1:0], 16'd0}),
    .den_i  (root_len),
    .sb_i   (rt_sb[DIF_W]),
    .vld_o  (uy_vld),
    .quo_o  (uy),
    .sb_o   (uy_sgn)
  );

  // ---------------------------------------------------------------- stage 5: partial products
  // High half of mag is clamped: once it reaches 2^21 any nonzero unit saturates velocity.
  logic [ACC_W-1:0]        mag_hi;
  logic                    s5_vld_q;
  side_t                   s5_side_q;
  logic [ACC_W+UNIT_W-1:0] s5_hx_q, s5_hy_q;
  logic [UNIT_W-1:0]       s5_lx_q, s5_ly_q;
  logic                    s5_sx_q, s5_sy_q;
  logic [16+UNIT_W-1:0]    lo_x, lo_y;

  always_comb begin
    mag_hi = (|mag[MAG_QW-1:16+ACC_W]) ? {ACC_W{1'b1}} : mag[16+ACC_W-1:16];
    lo_x   = (16+UNIT_W)'(mag[15:0]) * (16+UNIT_W)'(ux);
    lo_y   = (16+UNIT_W)'(mag[15:0]) * (16+UNIT_W)'(uy);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s5_vld_q <= 1'b0;
    else if (pipe_en) s5_vld_q <= mag_vld && ux_vld && uy_vld;
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s5_side_q <= mag_side;
      s5_hx_q   <= (ACC_W+UNIT_W)'(mag_hi) * (ACC_W+UNIT_W)'(ux);
      s5_hy_q   <= (ACC_W+UNIT_W)'(mag_hi) * (ACC_W+UNIT_W)'(uy);
      s5_lx_q   <= lo_x[16+UNIT_W-1:16];
      s5_ly_q   <= lo_y[16+UNIT_W-1:16];
      s5_sx_q   <= ux_sgn;
      s5_sy_q   <= uy_sgn;
    end
  end

  // ---------------------------------------------------------------- stage 6: new velocity
  logic [ACC_W+UNIT_W:0]   cx_sum, cy_sum;
  logic [ACC_W-1:0]        cx_sat, cy_sat;
  logic signed [ACC_W:0]   ax, ay;
  logic signed [VEL_W+2:0] vx_sum, vy_sum;
  logic signed [VEL_W-1:0] nvx, nvy;

  always_comb begin
    cx_sum = (ACC_W+UNIT_W+1)'(s5_hx_q) + (ACC_W+UNIT_W+1)'(s5_lx_q);
    cy_sum = (ACC_W+UNIT_W+1)'(s5_hy_q) + (ACC_W+UNIT_W+1)'(s5_ly_q);
    cx_sat = (|cx_sum[ACC_W+UNIT_W:ACC_W]) ? {ACC_W{1'b1}} : cx_sum[ACC_W-1:0];
    cy_sat = (|cy_sum[ACC_W+UNIT_W:ACC_W]) ? {ACC_W{1'b1}} : cy_sum[ACC_W-1:0];
    ax = s5_sx_q ? -$signed({1'b0, cx_sat}) : $signed({1'b0, cx_sat});
    ay = s5_sy_q ? -$signed({1'b0, cy_sat}) : $signed({1'b0, cy_sat});
    vx_sum = (VEL_W+3)'(s5_side_q.vx) + (VEL_W+3)'(ax);
    vy_sum = (VEL_W+3)'(s5_side_q.vy) + (VEL_W+3)'(ay);
    // Body sitting on the star center feels no pull.
    nvx = (s5_side_q.move && !s5_side_q.zero) ? sat_vel(vx_sum) : s5_side_q.vx;
    nvy = (s5_side_q.move && !s5_side_q.zero) ? sat_vel(vy_sum) : s5_side_q.vy;
  end

  logic                    s6_vld_q;
  side_t                   s6_side_q;
  logic signed [VEL_W-1:0] s6_nvx_q, s6_nvy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s6_vld_q <= 1'b0;
    else if (pipe_en) s6_vld_q <= s5_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s6_side_q <= s5_side_q;
      s6_nvx_q  <= nvx;
      s6_nvy_q  <= nvy;
    end
  end

  // ---------------------------------------------------------------- output stage: new position
  // Round velocity to position units: floor((v + 8) / 16).
  logic signed [VEL_W:0]   vrx, vry;
  logic signed [VEL_W-4:0] stx, sty;
  logic signed [POS_W-1:0] npx, npy;

  always_comb begin
    vrx = (VEL_W+1)'(s6_nvx_q) + (VEL_W+1)'(8);
    vry = (VEL_W+1)'(s6_nvy_q) + (VEL_W+1)'(8);
    stx = vrx[VEL_W:4];
    sty = vry[VEL_W:4];
    npx = s6_side_q.move ? sat_pos((POS_W+1)'(s6_side_q.px) + (POS_W+1)'(stx)) : s6_side_q.px;
    npy = s6_side_q.move ? sat_pos((POS_W+1)'(s6_side_q.py) + (POS_W+1)'(sty)) : s6_side_q.py;
  end

  logic [87:0] out_data_q;
  logic        out_rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (pipe_en) out_vld_q <= s6_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      out_data_q <= {s6_nvy_q, s6_nvx_q, npy, npx};
      out_rem_q  <= s6_side_q.hit;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_rem_q;

  // ---------------------------------------------------------------- checks
  `CGBS_ASSERT(a_lanes_aligned, (mag_vld == ux_vld) && (ux_vld == uy_vld), "divide lanes out of step")
  `CGBS_ASSERT_NEXT(a_stall_freeze, !pipe_en, $stable(s6_vld_q) && $stable(s5_vld_q), "pipeline moved during stall")
  `CGBS_ASSERT_NEXT(a_tail_reaches_out, pipe_en && s6_vld_q, m_axis_tvalid, "result lost before output")

endmodule
